### src/fmv_pkg.sv
// ----------------------------------------------------------------------------
// fmv_pkg
// Shared types, constants and the sine table generator for the FM voice.
// ----------------------------------------------------------------------------
package fmv_pkg;

	// default sizes
	localparam int DEF_SINE_ENTRIES = 1024;
	localparam int DEF_PHASE_BITS   = 32;

	// field widths
	localparam int STEP_W    = 32;
	localparam int INDEX_W   = 22;
	localparam int SAMPLE_W  = 16;
	localparam int PROD_W    = INDEX_W + SAMPLE_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	// table generation constants (Q30)
	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// request commands
	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_LOAD   = 1'b1
	} cmd_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD1_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOD2_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOD1_INDEX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOD2_INDEX   = 3'd4;

	// configuration register set
	typedef struct packed {
		logic        [STEP_W-1:0]  carrier_step;
		logic        [STEP_W-1:0]  mod1_step;
		logic        [STEP_W-1:0]  mod2_step;
		logic signed [INDEX_W-1:0] mod1_index;
		logic signed [INDEX_W-1:0] mod2_index;
	} fmv_cfg_t;

	// One sine table entry; sh places entry k on the 32-bit cycle scale.
	// Quarter-wave fold, then an 8-term Taylor series in Q30.
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(longint unsigned k, int sh);
		longint unsigned a;
		longint unsigned quad;
		longint unsigned r;
		longint          x;
		longint          sum;
		longint          term;
		longint          mag;
		a    = k << sh;
		quad = (a >> 30) & 64'd3;
		r    = a & 64'(Q30_ONE - 1);
		if (quad == 64'd1 || quad == 64'd3) begin
			r = 64'(Q30_ONE) - r;
		end
		x    = longint'((r * 64'(HALF_PI_Q30)) >> 30);
		sum  = x;
		term = x;
		for (int n = 1; n <= 7; n++) begin
			term = (term * x) >>> 30;
			term = (term * x) >>> 30;
			// divide by (2n)(2n+1)
			case (n)
				1: begin
					term = term / 64'sd6;
				end
				2: begin
					term = term / 64'sd20;
				end
				3: begin
					term = term / 64'sd42;
				end
				4: begin
					term = term / 64'sd72;
				end
				5: begin
					term = term / 64'sd110;
				end
				6: begin
					term = term / 64'sd156;
				end
				default: begin
					term = term / 64'sd210;
				end
			endcase
			if ((n % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > Q30_ONE) begin
			sum = Q30_ONE;
		end
		mag = (sum * 64'sd32767 + (Q30_ONE >>> 1)) >>> 30;
		if (quad >= 64'd2) begin
			mag = -mag;
		end
		return SAMPLE_W'(mag);
	endfunction

endpackage

### src/fmv_sine_rom.sv
// ----------------------------------------------------------------------------
// fmv_sine_rom
// Full-wave Q1.15 sine ROM, contents built at elaboration, registered read.
// ----------------------------------------------------------------------------
module fmv_sine_rom #(
	parameter int SINE_ENTRIES = fmv_pkg::DEF_SINE_ENTRIES
) (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [$clog2(SINE_ENTRIES)-1:0]       addr,
	output logic signed [fmv_pkg::SAMPLE_W-1:0]   rd_data
);
	import fmv_pkg::*;

	localparam int AW = $clog2(SINE_ENTRIES);

	typedef logic signed [SAMPLE_W-1:0] rom_t [SINE_ENTRIES];

	function automatic rom_t build_rom();
		rom_t t;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			t[k] = sine_entry(longint'(k), 32 - AW);
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	logic signed [SAMPLE_W-1:0] rd_data_q;

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ROM[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/fmv_cfg_regs.sv
// ----------------------------------------------------------------------------
// fmv_cfg_regs
// Configuration register file: steps and modulation indexes.
// ----------------------------------------------------------------------------
module fmv_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fmv_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [fmv_pkg::CFG_W-1:0]         cfg_data,
	output fmv_pkg::fmv_cfg_t                 cfg
);
	import fmv_pkg::*;

	fmv_cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CARRIER_STEP: cfg_q.carrier_step <= cfg_data[STEP_W-1:0];
				REG_MOD1_STEP:    cfg_q.mod1_step    <= cfg_data[STEP_W-1:0];
				REG_MOD2_STEP:    cfg_q.mod2_step    <= cfg_data[STEP_W-1:0];
				REG_MOD1_INDEX:   cfg_q.mod1_index   <= cfg_data[INDEX_W-1:0];
				REG_MOD2_INDEX:   cfg_q.mod2_index   <= cfg_data[INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/fmv_phase_acc.sv
// ----------------------------------------------------------------------------
// fmv_phase_acc
// Carrier and modulator phase accumulators: step on sample, load on command.
// ----------------------------------------------------------------------------
module fmv_phase_acc #(
	parameter int PHASE_BITS = fmv_pkg::DEF_PHASE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           acc_en,
	input  logic                           load,
	input  logic [fmv_pkg::STEP_W-1:0]     start_phase,
	input  fmv_pkg::fmv_cfg_t              cfg,
	output logic [PHASE_BITS-1:0]          carrier_phase,
	output logic [PHASE_BITS-1:0]          mod1_phase,
	output logic [PHASE_BITS-1:0]          mod2_phase
);
	import fmv_pkg::*;

	logic [PHASE_BITS-1:0] start_w;
	logic [PHASE_BITS-1:0] cstep_w;
	logic [PHASE_BITS-1:0] m1step_w;
	logic [PHASE_BITS-1:0] m2step_w;

	logic [PHASE_BITS-1:0] carrier_q;
	logic [PHASE_BITS-1:0] mod1_q;
	logic [PHASE_BITS-1:0] mod2_q;

	// fit 32-bit steps and start phase to the accumulator width
	if (PHASE_BITS <= STEP_W) begin : g_narrow
		assign start_w  = start_phase[PHASE_BITS-1:0];
		assign cstep_w  = cfg.carrier_step[PHASE_BITS-1:0];
		assign m1step_w = cfg.mod1_step[PHASE_BITS-1:0];
		assign m2step_w = cfg.mod2_step[PHASE_BITS-1:0];
	end else begin : g_wide
		assign start_w  = {{(PHASE_BITS-STEP_W){1'b0}}, start_phase};
		assign cstep_w  = {{(PHASE_BITS-STEP_W){1'b0}}, cfg.carrier_step};
		assign m1step_w = {{(PHASE_BITS-STEP_W){1'b0}}, cfg.mod1_step};
		assign m2step_w = {{(PHASE_BITS-STEP_W){1'b0}}, cfg.mod2_step};
	end

	// accumulators wrap modulo 2^PHASE_BITS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
			mod1_q    <= '0;
			mod2_q    <= '0;
		end else if (acc_en) begin
			if (load) begin
				carrier_q <= start_w;
				mod1_q    <= start_w;
				mod2_q    <= start_w;
			end else begin
				carrier_q <= carrier_q + cstep_w;
				mod1_q    <= mod1_q + m1step_w;
				mod2_q    <= mod2_q + m2step_w;
			end
		end
	end

	assign carrier_phase = carrier_q;
	assign mod1_phase    = mod1_q;
	assign mod2_phase    = mod2_q;

endmodule

### src/fm_two_modulator_synth_voice.sv
// ----------------------------------------------------------------------------
// fm_two_modulator_synth_voice
// Two-modulator FM voice: sin(carrier + i1*sin(mod1) + i2*sin(mod2)).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, cmd, start_phase): a sample request
//   (cmd = sample) yields one output sample; a load request (cmd = load)
//   sets all three phases to start_phase and yields nothing.
//   Output channel (out_valid / out_stall, sample): signed Q1.15 samples,
//   in request order.
//   Registers (cfg_we, cfg_idx, cfg_data): steps and indexes, to be written by
//   the user only while no sample request is in flight (not enforced by the block).
//   Pipeline: the mod sine ROM read is registered at the edge that accepts
//   a request, then comes the index multiply, then the carrier sine ROM
//   read, which is the output register.
//   Throughput: one request per cycle while in_stall is low; each stage is a
//   single ROM read or multiply, and stages fill bubbles independently.
//   Stall: while out_stall holds a result, earlier stages keep moving until
//   full; in_stall rises only when the whole pipe is occupied.
//   Reset: phases, registers and all valid flags clear; no output pending.
//   SINE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module fm_two_modulator_synth_voice #(
	parameter int SINE_ENTRIES = fmv_pkg::DEF_SINE_ENTRIES,
	parameter int PHASE_BITS   = fmv_pkg::DEF_PHASE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [fmv_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [fmv_pkg::CFG_W-1:0]            cfg_data,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic [fmv_pkg::STEP_W-1:0]           start_phase,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fmv_pkg::SAMPLE_W-1:0]  sample
);
	import fmv_pkg::*;

	localparam int AW    = $clog2(SINE_ENTRIES);
	localparam int EXT_W = (PHASE_BITS > SUM_W) ? PHASE_BITS : SUM_W;

	fmv_cfg_t cfg;

	logic [PHASE_BITS-1:0] carrier_phase;
	logic [PHASE_BITS-1:0] mod1_phase;
	logic [PHASE_BITS-1:0] mod2_phase;

	logic en_s1;
	logic en_s2;
	logic en_out;
	logic accept;
	logic is_load;

	logic                       valid_s1;
	logic [PHASE_BITS-1:0]      carrier_s1;
	logic signed [SAMPLE_W-1:0] sin1_s1;
	logic signed [SAMPLE_W-1:0] sin2_s1;

	logic                       valid_s2;
	logic [PHASE_BITS-1:0]      carrier_s2;
	logic signed [PROD_W-1:0]   prod1_s2;
	logic signed [PROD_W-1:0]   prod2_s2;

	logic                       out_valid_q;

	logic signed [SUM_W-1:0]    dev_sum;
	logic signed [EXT_W-1:0]    dev_ext;
	logic signed [EXT_W-1:0]    dev_shift;
	logic [PHASE_BITS-1:0]      arg;

	// register file
	fmv_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// stage enables: a stage moves when empty or when its successor moves
	assign en_out   = !out_valid_q || !out_stall;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;
	assign is_load  = (cmd == CMD_LOAD);

	// phase accumulators step on every accepted sample request and load on a load request
	fmv_phase_acc #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc_en        (accept),
		.load          (is_load),
		.start_phase   (start_phase),
		.cfg           (cfg),
		.carrier_phase (carrier_phase),
		.mod1_phase    (mod1_phase),
		.mod2_phase    (mod2_phase)
	);

	// stage 1: modulator sine reads at the pre-step phases
	fmv_sine_rom #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_rom_mod1 (
		.clk     (clk),
		.rd_en   (en_s1),
		.addr    (mod1_phase[PHASE_BITS-1 -: AW]),
		.rd_data (sin1_s1)
	);

	fmv_sine_rom #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_rom_mod2 (
		.clk     (clk),
		.rd_en   (en_s1),
		.addr    (mod2_phase[PHASE_BITS-1 -: AW]),
		.rd_data (sin2_s1)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			carrier_s1 <= carrier_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= accept && !is_load;
		end
	end

	// stage 2: index times sine, Q6.16 * Q1.15
	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod1_s2   <= PROD_W'(cfg.mod1_index) * PROD_W'(sin1_s1);
			prod2_s2   <= PROD_W'(cfg.mod2_index) * PROD_W'(sin2_s1);
			carrier_s2 <= carrier_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// deviation in units of 2^-31 of a full phase turn, scaled to phase units (floor on right shift)
	assign dev_sum = SUM_W'(prod1_s2) + SUM_W'(prod2_s2);
	assign dev_ext = EXT_W'(dev_sum);

	if (PHASE_BITS >= 31) begin : g_shl
		assign dev_shift = dev_ext <<< (PHASE_BITS - 31);
	end else begin : g_shr
		assign dev_shift = dev_ext >>> (31 - PHASE_BITS);
	end

	assign arg = carrier_s2 + dev_shift[PHASE_BITS-1:0];

	// output stage: carrier sine read is the result register
	fmv_sine_rom #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_rom_car (
		.clk     (clk),
		.rd_en   (en_out),
		.addr    (arg[PHASE_BITS-1 -: AW]),
		.rd_data (sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid = out_valid_q;

endmodule
